// ===== hw/rtl/fmcd_pkg.sv =====
package fmcd_pkg;

    // Frame store depth and fill count width (count runs up to STORE_BYTES + 1)
    localparam int STORE_BYTES = 32;
    localparam int FILL_W      = $clog2(STORE_BYTES + 2);

    // Only the head of the frame takes part in the mode compare: "modeN" and a zero byte
    localparam int HEAD_BYTES  = 6;

    // Bytes with a meaning
    localparam logic [7:0] CH_OPEN  = 8'h23;  // '#'
    localparam logic [7:0] CH_CLOSE = 8'h45;  // 'E'
    localparam logic [7:0] CH_FWD   = 8'h57;  // 'W'
    localparam logic [7:0] CH_REV   = 8'h53;  // 'S'
    localparam logic [7:0] CH_LEFT  = 8'h41;  // 'A'
    localparam logic [7:0] CH_RIGHT = 8'h44;  // 'D'
    localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
    localparam logic [7:0] CH_O     = 8'h6F;  // 'o'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
    localparam logic [7:0] CH_THREE = 8'h33;  // '3'
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Operating modes
    localparam logic [1:0] MODE_ONE   = 2'd1;  // remote drive
    localparam logic [1:0] MODE_TWO   = 2'd2;
    localparam logic [1:0] MODE_THREE = 2'd3;

    // Event kinds
    localparam logic EV_DRIVE = 1'b0;
    localparam logic EV_FRAME = 1'b1;

    typedef enum logic [2:0] {
        MOT_FWD   = 3'd0,
        MOT_REV   = 3'd1,
        MOT_LEFT  = 3'd2,
        MOT_RIGHT = 3'd3,
        MOT_HOLD  = 3'd4
    } t_motion;

    // Configuration register map (index = paddr[3:2])
    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_STRAIGHT = 2'd0;
    localparam logic [1:0]  REG_INNER    = 2'd1;
    localparam logic [1:0]  REG_OUTER    = 2'd2;

    localparam logic [15:0] RST_STRAIGHT = 16'd300;
    localparam logic [15:0] RST_INNER    = 16'd150;
    localparam logic [15:0] RST_OUTER    = 16'd400;

    typedef struct packed {
        logic        event_res;
        t_motion     motion;
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [1:0]  mode_now;
    } t_result;

endpackage

// ===== hw/rtl/framed_mode_command_decoder.sv =====
// Framed mode command decoder.
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per transfer.
// Output channel: o_valid / i_stall carry one event (type, motion, wheel speeds, mode).
// In drive mode W/S/A/D give a drive event; 'E' closes a frame and reports the mode,
// switching it when the frame held "mode1", "mode2" or "mode3" and a zero byte.
// '#' opens a frame; following bytes are counted until the store is full, only the head is kept.
// Speeds come from an APB register bank (straight, turn inner, turn outer at 0x0/0x4/0x8).
// Throughput: one byte per cycle while o_stall is low. An event reaches o_valid from the
// result register; all decode and frame update is one pass into the result register.
// Bytes that cause no event only update state.
// A skid register sits behind the result register, so a byte is still taken while a
// result waits; o_stall rises only when both hold an undelivered event.
// Reset (synchronous, active low): mode 1, no frame open, store cleared, output empty,
// speeds back to 300/150/400.
module framed_mode_command_decoder
    import fmcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    // event output
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_event_res,
    output logic [2:0]        o_motion,
    output logic [15:0]       o_left_speed,
    output logic [15:0]       o_right_speed,
    output logic [1:0]        o_mode_now,
    // APB register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------- registers
    logic [15:0] r_straight, r_inner, r_outer;

    logic [7:0]        r_head [HEAD_BYTES];   // first bytes of the frame store
    logic [7:0]        n_head [HEAD_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_mode, n_mode;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    // ---------------------------------------------------------------- APB
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_straight <= RST_STRAIGHT;
            r_inner    <= RST_INNER;
            r_outer    <= RST_OUTER;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STRAIGHT: r_straight <= pwdata[15:0];
                REG_INNER:    r_inner    <= pwdata[15:0];
                REG_OUTER:    r_outer    <= pwdata[15:0];
                default: ;    // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STRAIGHT: prdata = {16'd0, r_straight};
            REG_INNER:    prdata = {16'd0, r_inner};
            REG_OUTER:    prdata = {16'd0, r_outer};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- decode
    logic    in_fire, out_fire;
    logic    has_res;
    t_result res;
    logic    head_mode;

    assign in_fire  = i_valid && !o_stall;
    assign out_fire = r_out_valid && !i_stall;

    // "mode" prefix with a zero byte after the digit
    assign head_mode = (r_head[0] == CH_M) && (r_head[1] == CH_O) && (r_head[2] == CH_D)
                    && (r_head[3] == CH_E) && (r_head[5] == CH_NUL);

    always_comb begin
        has_res         = 1'b0;
        res.event_res   = EV_DRIVE;
        res.motion      = MOT_HOLD;
        res.left_speed  = 16'd0;
        res.right_speed = 16'd0;
        n_mode          = r_mode;
        n_fill          = r_fill;
        n_head          = r_head;

        // drive letters, only in remote drive mode
        if (r_mode == MODE_ONE) begin
            case (i_rx_byte)
                CH_FWD: begin
                    has_res         = 1'b1;
                    res.motion      = MOT_FWD;
                    res.left_speed  = r_straight;
                    res.right_speed = r_straight;
                end
                CH_REV: begin
                    has_res         = 1'b1;
                    res.motion      = MOT_REV;
                    res.left_speed  = r_straight;
                    res.right_speed = r_straight;
                end
                CH_LEFT: begin
                    has_res         = 1'b1;
                    res.motion      = MOT_LEFT;
                    res.left_speed  = r_inner;
                    res.right_speed = r_outer;
                end
                CH_RIGHT: begin
                    has_res         = 1'b1;
                    res.motion      = MOT_RIGHT;
                    res.left_speed  = r_outer;
                    res.right_speed = r_inner;
                end
                default: ;
            endcase
        end

        // framing
        if (i_rx_byte == CH_OPEN) begin
            n_fill = FILL_W'(1);
        end else if (i_rx_byte == CH_CLOSE) begin
            if (head_mode) begin
                case (r_head[4])
                    CH_ONE:   n_mode = MODE_ONE;
                    CH_TWO:   n_mode = MODE_TWO;
                    CH_THREE: n_mode = MODE_THREE;
                    default:  ;
                endcase
            end
            for (int k = 0; k < HEAD_BYTES; k++) begin
                n_head[k] = CH_NUL;
            end
            n_fill          = '0;
            has_res         = 1'b1;
            res.event_res   = EV_FRAME;
            res.motion      = MOT_HOLD;
            res.left_speed  = 16'd0;
            res.right_speed = 16'd0;
        end else if (r_fill != '0 && r_fill <= FILL_W'(STORE_BYTES)) begin
            // slots past the head are never compared, so they are not kept
            for (int k = 0; k < HEAD_BYTES; k++) begin
                if (r_fill == FILL_W'(k + 1)) begin
                    n_head[k] = i_rx_byte;
                end
            end
            n_fill = r_fill + FILL_W'(1);
        end

        res.mode_now = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_mode <= MODE_ONE;
            for (int k = 0; k < HEAD_BYTES; k++) begin
                r_head[k] <= CH_NUL;
            end
        end else if (in_fire) begin
            r_fill <= n_fill;
            r_mode <= n_mode;
            r_head <= n_head;
        end
    end

    // ---------------------------------------------------------------- result + skid
    logic new_res;
    assign new_res = in_fire && has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled; drain skid into the result register
            if (out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (new_res) begin
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (new_res) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out.event_res;
    assign o_motion      = r_out.motion;
    assign o_left_speed  = r_out.left_speed;
    assign o_right_speed = r_out.right_speed;
    assign o_mode_now    = r_out.mode_now;

    // ---------------------------------------------------------------- assertions
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a transfer while result register is empty");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_rx_byte == CH_CLOSE) |=> (r_fill == '0 && o_valid))
        else $error("frame close did not clear fill count or produce an event");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STORE_BYTES + 1))
        else $error("fill count past end of store");

    a_open_sets_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_rx_byte == CH_OPEN) |=> (r_fill == FILL_W'(1)))
        else $error("frame open did not restart fill count");

endmodule

// ===== bench/fmcd_tb_pkg.sv =====
package fmcd_tb_pkg;
    import fmcd_pkg::*;

    // 'C' records the letter in drive mode but issues no command
    localparam logic [7:0] CH_CRUISE = 8'h43;

    // slot index width of the frame store
    localparam int SLOT_W = $clog2(STORE_BYTES);

    class fmcd_scoreboard;
        logic [7:0]        frame_bytes [STORE_BYTES];
        logic [FILL_W-1:0] fill;
        logic [1:0]        mode;
        logic [7:0]        last_letter;
        logic [15:0]       spd_straight;
        logic [15:0]       spd_inner;
        logic [15:0]       spd_outer;
        t_result           due_events [$];
        int                errors;

        function new();
            clear_frame();
            fill         = '0;
            mode         = MODE_ONE;
            last_letter  = CH_NUL;
            spd_straight = RST_STRAIGHT;
            spd_inner    = RST_INNER;
            spd_outer    = RST_OUTER;
            errors       = 0;
        endfunction

        function void clear_frame();
            foreach (frame_bytes[i]) frame_bytes[i] = CH_NUL;
        endfunction

        function void set_speed(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_STRAIGHT: spd_straight = value;
                REG_INNER:    spd_inner    = value;
                REG_OUTER:    spd_outer    = value;
                default: ;
            endcase
        endfunction

        // "modeN" then a zero byte at the head of the frame
        function bit head_reads_mode(logic [7:0] digit);
            return frame_bytes[0] == CH_M && frame_bytes[1] == CH_O &&
                   frame_bytes[2] == CH_D && frame_bytes[3] == CH_E &&
                   frame_bytes[4] == digit && frame_bytes[5] == CH_NUL;
        endfunction

        function t_result make_event(logic kind, t_motion mot, logic [15:0] lspd,
                                     logic [15:0] rspd);
            t_result ev;
            ev.event_res   = kind;
            ev.motion      = mot;
            ev.left_speed  = lspd;
            ev.right_speed = rspd;
            ev.mode_now    = mode;
            return ev;
        endfunction

        // One byte transfer into the block: update state, queue any event it causes
        function void take_byte(logic [7:0] b);
            t_result ev;
            bit      fired;
            fired = 1'b0;
            if (mode == MODE_ONE) begin
                case (b)
                    CH_FWD: begin
                        last_letter = b;
                        ev    = make_event(EV_DRIVE, MOT_FWD, spd_straight, spd_straight);
                        fired = 1'b1;
                    end
                    CH_REV: begin
                        last_letter = b;
                        ev    = make_event(EV_DRIVE, MOT_REV, spd_straight, spd_straight);
                        fired = 1'b1;
                    end
                    CH_LEFT: begin
                        last_letter = b;
                        ev    = make_event(EV_DRIVE, MOT_LEFT, spd_inner, spd_outer);
                        fired = 1'b1;
                    end
                    CH_RIGHT: begin
                        last_letter = b;
                        ev    = make_event(EV_DRIVE, MOT_RIGHT, spd_outer, spd_inner);
                        fired = 1'b1;
                    end
                    CH_CRUISE: last_letter = b;
                    default: ;
                endcase
            end

            if (b == CH_OPEN) begin
                fill = FILL_W'(1);
            end else if (b == CH_CLOSE) begin
                if (head_reads_mode(CH_ONE))
                    mode = MODE_ONE;
                else if (head_reads_mode(CH_TWO))
                    mode = MODE_TWO;
                else if (head_reads_mode(CH_THREE))
                    mode = MODE_THREE;
                clear_frame();
                fill  = '0;
                ev    = make_event(EV_FRAME, MOT_HOLD, 16'd0, 16'd0);
                fired = 1'b1;
            end else if (fill != 0 && fill <= STORE_BYTES) begin
                frame_bytes[SLOT_W'(fill - 1'b1)] = b;
                fill = fill + 1'b1;
            end

            if (fired) due_events.push_back(ev);
        endfunction

        function void match_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // One event transfer out of the block, against the oldest expectation
        function void check_event(logic ev_res, logic [2:0] mot, logic [15:0] lspd,
                                  logic [15:0] rspd, logic [1:0] mode_now);
            t_result want;
            if (due_events.size() == 0) begin
                $error("event with none expected: event_res %0d motion %0d mode %0d",
                       ev_res, mot, mode_now);
                errors++;
                return;
            end
            want = due_events.pop_front();
            match_field("event_res", 16'(want.event_res), 16'(ev_res));
            match_field("motion", 16'(want.motion), 16'(mot));
            match_field("left_speed", want.left_speed, lspd);
            match_field("right_speed", want.right_speed, rspd);
            match_field("mode_now", 16'(want.mode_now), 16'(mode_now));
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        function void flag_leftover();
            if (due_events.size() != 0) begin
                $error("%0d expected events never arrived", due_events.size());
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== bench/tb_framed_mode_command_decoder.sv =====
module tb_framed_mode_command_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import fmcd_pkg::*;
    import fmcd_tb_pkg::*;

    // Longest quiet stretch is the deliberate receiver hold-off; the limit is far above it
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASES         = 8;
    localparam int PHASE_BYTES    = 95;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              o_stall;
    logic [7:0]        i_rx_byte = '0;
    logic              o_valid;
    logic              i_stall   = 1'b0;
    logic              o_event_res;
    logic [2:0]        o_motion;
    logic [15:0]       o_left_speed;
    logic [15:0]       o_right_speed;
    logic [1:0]        o_mode_now;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    fmcd_scoreboard sb = new();

    // calm: neither side idles during this phase
    bit  calm;
    // set by the stimulus, taken up by the receiver for one long hold-off
    bit  hold_request;
    int  bytes_sent;
    int  quiet_cycles;

    logic [7:0] drive_letters [5] = '{CH_FWD, CH_REV, CH_LEFT, CH_RIGHT, CH_CRUISE};

    framed_mode_command_decoder DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: both channels sampled at the edge, byte first so its event can follow
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.take_byte(i_rx_byte);
            if (o_valid && !i_stall)
                sb.check_event(o_event_res, o_motion, o_left_speed, o_right_speed,
                               o_mode_now);
        end
    end

    // Watchdog: cycles with no transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Event receiver: random stall before each transfer, one long hold-off on request
    initial begin
        int wait_cycles;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            wait_cycles = calm ? 0 : $urandom_range(0, 3);
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // One byte transfer; valid stays high into the next byte when no gap is drawn
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_letter();
        send_byte(drive_letters[3'($urandom_range(0, 4))]);
    endtask

    // '#' "modeN" [zero byte] [junk] 'E'
    task automatic send_mode_frame(input logic [7:0] digit, input bit with_nul,
                                   input int junk);
        send_byte(CH_OPEN);
        send_byte(CH_M);
        send_byte(CH_O);
        send_byte(CH_D);
        send_byte(CH_E);
        send_byte(digit);
        if (with_nul) send_byte(CH_NUL);
        repeat (junk) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_CLOSE);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_speed(idx, value);
    endtask

    task automatic set_speeds(input logic [15:0] straight, input logic [15:0] inner,
                              input logic [15:0] outer);
        apb_write(REG_STRAIGHT, straight);
        apb_write(REG_INNER, inner);
        apb_write(REG_OUTER, outer);
    endtask

    // Drain: every event delivered, then a wait for bytes still in the pipe
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed drive bursts and frames, some broken frames and noise
    task automatic random_sequence();
        int         pick;
        logic [7:0] digit;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: repeat ($urandom_range(1, 8)) send_letter();
            3, 4: begin
                // drive mode favoured so drive events keep coming
                digit = ($urandom_range(0, 1) != 0) ? CH_ONE :
                        (($urandom_range(0, 1) != 0) ? CH_TWO : CH_THREE);
                send_mode_frame(digit, 1'b1, 0);
            end
            5: begin
                // near miss: digit from '0' to '4', zero byte and junk optional
                digit = 8'(CH_ONE + $urandom_range(0, 4) - 1);
                send_mode_frame(digit, 1'($urandom_range(0, 1)), $urandom_range(0, 2));
            end
            6: begin
                // fill the store up to and past its end, usually closed afterwards
                send_byte(CH_OPEN);
                repeat ($urandom_range(26, 40)) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) != 0) send_byte(CH_CLOSE);
            end
            7: begin
                // reopened frame: '#' leaves the old bytes behind
                send_byte(CH_OPEN);
                repeat ($urandom_range(1, 7)) send_byte(8'($urandom_range(0, 255)));
                send_mode_frame(CH_ONE, 1'($urandom_range(0, 1)), 0);
            end
            8: send_byte(CH_CLOSE);   // close with no frame open
            default: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    initial begin
        int phase;
        int phase_start;
        calm         = 1'b0;
        hold_request = 1'b0;
        bytes_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every drive letter at reset speeds, switch to mode 2, a letter
        // ignored outside drive mode, close with no frame, back to mode 1 relying on
        // the cleared store for the zero byte, then the byte extremes
        foreach (drive_letters[k]) send_byte(drive_letters[k]);
        send_mode_frame(CH_TWO, 1'b1, 0);
        send_byte(CH_FWD);
        send_byte(CH_CLOSE);
        send_mode_frame(CH_ONE, 1'b0, 0);
        send_byte(8'hFF);
        send_byte(CH_NUL);

        for (phase = 0; phase < PHASES; phase++) begin
            // first phase keeps the reset speeds
            if (phase != 0) begin
                settle();
                case (phase)
                    1: set_speeds(16'h0000, 16'h0000, 16'h0000);
                    2: set_speeds(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    4: set_speeds(16'h0001, 16'hFFFF, 16'h8000);
                    default: set_speeds(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)));
                endcase
            end
            calm = (phase == 5) || ($urandom_range(0, 3) == 0);

            if (phase == 3) begin
                // fill-up: drive mode, receiver holds off, letters keep coming
                send_mode_frame(CH_ONE, 1'b1, 0);
                hold_request = 1'b1;
                repeat (40) send_letter();
            end

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) random_sequence();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.flag_leftover();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
